// File: sv/gsa_pkg.sv
`default_nettype none

package gsa_pkg;

   localparam int MAX_STATES = 4096;
   localparam int ALPHABET   = 26;
   localparam int ST_W       = $clog2(MAX_STATES);
   localparam int USED_W     = ST_W + 1;
   localparam int SYM_W      = 5;
   localparam int CNT_W      = 24;

   typedef logic [ALPHABET-1:0][ST_W-1:0] row_type;

   typedef enum logic [11:0] {
      ST_CLEAR = 12'b0000_0000_0001,
      ST_IDLE  = 12'b0000_0000_0010,
      ST_EDGE  = 12'b0000_0000_0100,
      ST_RD    = 12'b0000_0000_1000,
      ST_CHK   = 12'b0000_0001_0000,
      ST_LRD   = 12'b0000_0010_0000,
      ST_SPL   = 12'b0000_0100_0000,
      ST_CPY   = 12'b0000_1000_0000,
      ST_LNK   = 12'b0001_0000_0000,
      ST_RET   = 12'b0010_0000_0000,
      ST_FIN   = 12'b0100_0000_0000,
      ST_DONE  = 12'b1000_0000_0000
   } state_type;

   typedef struct packed {
      logic clear;
      logic accept;
      logic edge_chk;
      logic walk_rd;
      logic walk_chk;
      logic len_rd;
      logic spl;
      logic cpy;
      logic lnk;
      logic ret;
      logic fin;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic reject;
      logic full;
      logic nxt_zero;
      logic match;
      logic node_root;
      logic clone_phase;
      logic ctx_link;
      logic len_eq;
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

// File: sv/gsa_if.sv
`default_nettype none

interface gsa_req_if;
   import gsa_pkg::*;
   logic             valid;
   logic             ready;
   logic [SYM_W-1:0] symbol;
   logic             mode;
   modport source (output valid, symbol, mode, input ready);
   modport sink   (input valid, symbol, mode, output ready);
endinterface

interface gsa_rsp_if;
   import gsa_pkg::*;
   logic             valid;
   logic             ready;
   logic [ST_W-1:0]  new_state;
   logic [ST_W-1:0]  state_length;
   logic [CNT_W-1:0] distinct_substrings;
   logic             table_full;
   modport source (output valid, new_state, state_length, distinct_substrings, table_full,
                   input ready);
   modport sink   (input valid, new_state, state_length, distinct_substrings, table_full,
                   output ready);
endinterface

`default_nettype wire

// File: sv/generalized_suffix_automaton.sv
`default_nettype none

// channel   dir  signals                                             beat when
// req_ch    in   symbol[4:0] mode                                    valid & ready
// rsp_ch    out  new_state[11:0] state_length[11:0]                  valid & ready
//                distinct_substrings[23:0] table_full
//
// One item at a time. A rejected item goes from the accept straight to the result load;
// otherwise the edge is checked. An existing edge reads its target's length and splits,
// cloning (copy, link, redirect walk) when it is not solid. A new state walks the suffix
// links, redirecting edges, then either ends at the root or splits at the stopping node's
// edge, which may clone; its link and the count are then written before the load.
// After reset the CLEAR state clears the root row with ready low; a result waits in the
// output register while the next item is taken, and that item's load stalls until it leaves.

module generalized_suffix_automaton
   import gsa_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   gsa_req_if.sink    req_ch,
   gsa_rsp_if.source  rsp_ch
);

   cmd_type  cmd;
   stat_type stat;

   gsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   gsa_dp u_dp (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .stat                    (stat),
      .req_symbol              (req_ch.symbol),
      .req_mode                (req_ch.mode),
      .rsp_valid               (rsp_ch.valid),
      .rsp_ready               (rsp_ch.ready),
      .rsp_new_state           (rsp_ch.new_state),
      .rsp_state_length        (rsp_ch.state_length),
      .rsp_distinct_substrings (rsp_ch.distinct_substrings),
      .rsp_table_full          (rsp_ch.table_full)
   );

   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !req_ch.ready)
      else $error("accepting before root row is cleared");

   // a result flagged full implies the store is full from then on
   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.table_full |-> stat.full)
      else $error("full flag without a full store");

   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.load) && !$past(reset) && $past(rsp_ch.valid) |->
         rsp_ch.distinct_substrings >= $past(rsp_ch.distinct_substrings))
      else $error("distinct count went down");

endmodule

`default_nettype wire

// File: sv/gsa_ctrl.sv
`default_nettype none

module gsa_ctrl
   import gsa_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd          = '0;
      cmd.clear    = (state_ff == ST_CLEAR);
      cmd.accept   = (state_ff == ST_IDLE) && req_valid;
      cmd.edge_chk = (state_ff == ST_EDGE);
      cmd.walk_rd  = (state_ff == ST_RD);
      cmd.walk_chk = (state_ff == ST_CHK);
      cmd.len_rd   = (state_ff == ST_LRD);
      cmd.spl      = (state_ff == ST_SPL);
      cmd.cpy      = (state_ff == ST_CPY);
      cmd.lnk      = (state_ff == ST_LNK);
      cmd.ret      = (state_ff == ST_RET);
      cmd.fin      = (state_ff == ST_FIN);
      cmd.load     = (state_ff == ST_DONE) && stat.out_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_valid) state_in = stat.reject ? ST_DONE : ST_EDGE;
         end
         ST_EDGE:  state_in = stat.nxt_zero ? ST_RD : ST_LRD;
         ST_RD:    state_in = ST_CHK;
         ST_CHK: begin
            if (stat.match && !stat.node_root) begin
               state_in = ST_RD;
            end else if (stat.clone_phase) begin
               state_in = ST_RET;
            end else if (stat.match) begin
               // walked past the root: link goes to the root
               state_in = ST_FIN;
            end else begin
               state_in = ST_LRD;
            end
         end
         ST_LRD:   state_in = ST_SPL;
         ST_SPL:   state_in = stat.len_eq ? ST_RET : ST_CPY;
         ST_CPY:   state_in = ST_LNK;
         ST_LNK:   state_in = ST_RD;
         ST_RET:   state_in = stat.ctx_link ? ST_FIN : ST_DONE;
         ST_FIN:   state_in = ST_DONE;
         ST_DONE: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default:  state_in = ST_CLEAR;
      endcase
   end

endmodule

`default_nettype wire

// File: sv/gsa_dp.sv
`default_nettype none

module gsa_dp
   import gsa_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cmd_type          cmd,
   output stat_type             stat,
   input  wire logic [SYM_W-1:0] req_symbol,
   input  wire logic             req_mode,
   output logic                 rsp_valid,
   input  wire logic             rsp_ready,
   output logic [ST_W-1:0]      rsp_new_state,
   output logic [ST_W-1:0]      rsp_state_length,
   output logic [CNT_W-1:0]     rsp_distinct_substrings,
   output logic                 rsp_table_full
);

   // memories: transition rows, suffix links, lengths
   row_type             trans_mem [MAX_STATES];
   logic [ST_W-1:0]     link_mem  [MAX_STATES];
   logic [ST_W-1:0]     len_mem   [MAX_STATES];
   row_type             row_q;
   logic [ST_W-1:0]     link_q, len_q;

   logic [USED_W-1:0]   used_ff, used_in;
   logic [ST_W-1:0]     last_ff, last_in, last_len_ff, last_len_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [SYM_W-1:0]    sym_ff;
   logic                full_ff;
   logic [ST_W-1:0]     u_ff, node_ff, from_ff, to_ff, p_ff, lenp_ff, tgt_ff, cl_ff;
   logic [ST_W-1:0]     res_ff, reslen_ff, w_ff, lenw_ff;
   logic                clone_phase_ff, ctx_link_ff;
   logic [ST_W-1:0]     new_state_ff, state_length_ff;
   logic [CNT_W-1:0]    distinct_ff;
   logic                table_full_ff;

   logic [ST_W-1:0]     u_in, rd_addr, cur, nxt, lenu, lenp1, gain;
   logic                full_now;
   logic [CNT_W:0]      sum;

   logic                t_row_we, t_lane_we, l_we, n_we;
   logic [ST_W-1:0]     t_wa, l_wa, l_wd, n_wa, n_wd;
   row_type             t_row_wd;

   assign full_now = used_ff > USED_W'(MAX_STATES - 2);
   assign u_in     = req_mode ? '0 : last_ff;
   assign rd_addr  = cmd.accept ? u_in : ((cmd.len_rd || cmd.spl) ? tgt_ff : node_ff);
   assign cur      = row_q[sym_ff];
   assign nxt      = cur;
   assign lenu     = (u_ff == '0) ? '0 : len_q;
   assign lenp1    = lenp_ff + ST_W'(1);
   assign gain     = lenw_ff - reslen_ff;
   assign sum      = {1'b0, count_ff} + (CNT_W + 1)'(gain);

   always_comb begin
      stat             = '0;
      stat.reject      = full_now || (req_symbol >= SYM_W'(ALPHABET));
      stat.full        = full_now;
      stat.nxt_zero    = (nxt == '0);
      stat.match       = (cur == from_ff);
      stat.node_root   = (node_ff == '0);
      stat.clone_phase = clone_phase_ff;
      stat.ctx_link    = ctx_link_ff;
      stat.len_eq      = (lenp1 == len_q);
      stat.out_free    = !rsp_valid_ff || rsp_ready;
   end

   // memory write selection
   always_comb begin
      t_row_we  = cmd.clear || (cmd.edge_chk && nxt == '0) || cmd.cpy;
      t_lane_we = cmd.walk_chk && (cur == from_ff);
      t_wa      = cmd.clear ? '0 : (cmd.edge_chk ? used_ff[ST_W-1:0] :
                                   (cmd.cpy ? cl_ff : node_ff));
      t_row_wd  = cmd.cpy ? row_q : '0;
      l_we      = cmd.cpy || cmd.lnk || cmd.fin;
      l_wa      = cmd.cpy ? cl_ff : (cmd.lnk ? tgt_ff : w_ff);
      l_wd      = cmd.cpy ? link_q : (cmd.lnk ? cl_ff : res_ff);
      n_we      = (cmd.edge_chk && nxt == '0) || cmd.cpy;
      n_wa      = cmd.cpy ? cl_ff : used_ff[ST_W-1:0];
      n_wd      = cmd.cpy ? lenp1 : lenu + ST_W'(1);
   end

   always_ff @(posedge clock) begin
      if (t_row_we) begin
         trans_mem[t_wa] <= t_row_wd;
      end else if (t_lane_we) begin
         trans_mem[t_wa][sym_ff] <= to_ff;
      end
      row_q <= trans_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (l_we) link_mem[l_wa] <= l_wd;
      link_q <= link_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (n_we) len_mem[n_wa] <= n_wd;
      len_q <= len_mem[rd_addr];
   end

   // control state
   always_comb begin
      used_in      = used_ff;
      last_in      = last_ff;
      last_len_in  = last_len_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.edge_chk && nxt == '0) used_in = used_ff + USED_W'(1);
      if (cmd.spl && !(lenp1 == len_q)) used_in = used_ff + USED_W'(1);
      if (cmd.ret && !ctx_link_ff) begin
         last_in     = res_ff;
         last_len_in = reslen_ff;
      end
      if (cmd.fin) begin
         last_in     = w_ff;
         last_len_in = lenw_ff;
         count_in    = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
      end
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= USED_W'(1);
         last_ff      <= '0;
         last_len_ff  <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         last_ff      <= last_in;
         last_len_ff  <= last_len_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sym_ff  <= req_symbol;
         full_ff <= full_now;
         u_ff    <= u_in;
      end
      if (cmd.edge_chk) begin
         if (nxt != '0) begin
            p_ff        <= u_ff;
            lenp_ff     <= lenu;
            tgt_ff      <= nxt;
            ctx_link_ff <= 1'b0;
         end else begin
            w_ff           <= used_ff[ST_W-1:0];
            lenw_ff        <= lenu + ST_W'(1);
            node_ff        <= u_ff;
            from_ff        <= '0;
            to_ff          <= used_ff[ST_W-1:0];
            clone_phase_ff <= 1'b0;
            ctx_link_ff    <= 1'b1;
         end
      end
      if (cmd.walk_chk) begin
         if (cur == from_ff) begin
            if (node_ff != '0) begin
               node_ff <= link_q;
            end else if (!clone_phase_ff) begin
               res_ff    <= '0;
               reslen_ff <= '0;
            end
         end else if (!clone_phase_ff) begin
            p_ff    <= node_ff;
            lenp_ff <= (node_ff == '0) ? '0 : len_q;
            tgt_ff  <= cur;
         end
      end
      if (cmd.spl) begin
         res_ff    <= tgt_ff;
         reslen_ff <= lenp1;
         cl_ff     <= used_ff[ST_W-1:0];
      end
      if (cmd.lnk) begin
         node_ff        <= p_ff;
         from_ff        <= tgt_ff;
         to_ff          <= cl_ff;
         clone_phase_ff <= 1'b1;
         res_ff         <= cl_ff;
         reslen_ff      <= lenp1;
      end
      if (cmd.load) begin
         new_state_ff    <= last_ff;
         state_length_ff <= last_len_ff;
         distinct_ff     <= count_ff;
         table_full_ff   <= full_ff;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_new_state           = new_state_ff;
   assign rsp_state_length        = state_length_ff;
   assign rsp_distinct_substrings = distinct_ff;
   assign rsp_table_full          = table_full_ff;

endmodule

`default_nettype wire

// File: tb/gsa_tb_if.sv
`timescale 1ns / 100ps

// Interfaces are compiled from the RTL's gsa_if.sv; this file only keeps
// the beat record shared by the testbench.
package gsa_tb_pkg;
   import gsa_pkg::*;

   typedef struct {
      logic [ST_W-1:0]  new_state;
      logic [ST_W-1:0]  state_length;
      logic [CNT_W-1:0] distinct_substrings;
      logic             table_full;
   } gsa_result_type;
endpackage

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import gsa_pkg::*;
   import gsa_tb_pkg::*;

   localparam int NO_LINK   = -1;
   localparam int COUNT_MAX = (1 << CNT_W) - 1;
   localparam int WDOG_MAX  = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   errors = 0;

   gsa_req_if req_ch ();
   gsa_rsp_if rsp_ch ();

   generalized_suffix_automaton uut (.clock(clock), .reset(reset), .req_ch(req_ch),
                                     .rsp_ch(rsp_ch));

   always #6 clock = ~clock;

   task automatic report(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // Suffix automaton mirror and queue of expected result beats.
   class automaton_board;
      int             edges[int];
      int             link[MAX_STATES];
      int             len[MAX_STATES];
      int             used;
      int             last;
      int             count;
      gsa_result_type pending[$];

      function new();
         link[0] = NO_LINK;
         len[0] = 0;
         used = 1;
         last = 0;
         count = 0;
      endfunction

      function int edge_of(int n, int s);
         return edges.exists(n * ALPHABET + s) ? edges[n * ALPHABET + s] : 0;
      endfunction

      function int walk_redirect(int n, int s, int from, int to);
         while (n != NO_LINK && edge_of(n, s) == from) begin
            edges[n * ALPHABET + s] = to;
            n = link[n];
         end
         return n;
      endfunction

      function int solid_target(int n, int s, int t);
         int c;
         int k;
         int dummy;
         if (len[n] + 1 == len[t]) return t;
         c = used++;
         for (k = 0; k < ALPHABET; k++)
            if (edge_of(t, k) != 0) edges[c * ALPHABET + k] = edge_of(t, k);
         link[c] = link[t];
         len[c] = len[n] + 1;
         link[t] = c;
         dummy = walk_redirect(n, s, t, c);
         return c;
      endfunction

      function void note_input(logic [SYM_W-1:0] sym, logic mode);
         gsa_result_type r;
         int u, nx, w, p, lk, gain, s;
         s = sym;
         r.table_full = 1'b0;
         if (used + 2 > MAX_STATES) begin
            r.table_full = 1'b1;
         end else if (s < ALPHABET) begin
            u = mode ? 0 : last;
            nx = edge_of(u, s);
            if (nx != 0) begin
               w = solid_target(u, s, nx);
            end else begin
               w = used++;
               for (int k = 0; k < ALPHABET; k++) edges.delete(w * ALPHABET + k);
               link[w] = NO_LINK;
               len[w] = len[u] + 1;
               p = walk_redirect(u, s, 0, w);
               lk = (p == NO_LINK) ? 0 : solid_target(p, s, edge_of(p, s));
               link[w] = lk;
               gain = len[w] - len[lk];
               count = (gain > COUNT_MAX - count) ? COUNT_MAX : count + gain;
            end
            last = w;
         end
         r.new_state = ST_W'(last);
         r.state_length = ST_W'(len[last]);
         r.distinct_substrings = CNT_W'(count);
         pending = {pending, r};
      endfunction

      task check_result(gsa_result_type got);
         gsa_result_type want;
         if (pending.size() == 0) begin
            report("unexpected result beat", 1, 0);
            return;
         end
         want = pending.pop_front();
         if (got.new_state !== want.new_state)
            report("new_state", got.new_state, want.new_state);
         if (got.state_length !== want.state_length)
            report("state_length", got.state_length, want.state_length);
         if (got.distinct_substrings !== want.distinct_substrings)
            report("distinct_substrings", got.distinct_substrings, want.distinct_substrings);
         if (got.table_full !== want.table_full)
            report("table_full", got.table_full, want.table_full);
      endtask
   endclass

   automaton_board board = new();
   int  idle_cycles = 0;
   bit  hold_rsp = 1'b0;

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Monitor and watchdog at the rising edge.
   always @(posedge clock) begin
      gsa_result_type got;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) board.note_input(req_ch.symbol, req_ch.mode);
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.new_state = rsp_ch.new_state;
            got.state_length = rsp_ch.state_length;
            got.distinct_substrings = rsp_ch.distinct_substrings;
            got.table_full = rsp_ch.table_full;
            board.check_result(got);
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WDOG_MAX) begin
            $display("testbench: FAIL");
            $finish;
         end
      end
   end

   // Result side: random stalls, or a long hold while hold_rsp is set.
   initial begin
      int g;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (400) @(negedge clock);
            hold_rsp = 1'b0;
         end
         g = gap_length();
         if (g > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (g) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(negedge clock);
      end
   end

   task automatic send_letter(input logic [SYM_W-1:0] sym, input logic mode, input bit gaps);
      int g;
      g = gaps ? gap_length() : 0;
      if (g > 0) begin
         req_ch.valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.symbol <= sym;
      req_ch.mode <= mode;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic send_word(input int n, input int alpha);
      send_letter(SYM_W'($urandom_range(0, alpha - 1)), 1'b1, 1'b1);
      for (int i = 1; i < n; i++)
         send_letter(SYM_W'($urandom_range(0, alpha - 1)), 1'b0, 1'b1);
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.symbol = '0;
      req_ch.mode = 1'b0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      // directed: extremes, repeats that force clones, restarts, symbols out of range
      send_letter(5'd0, 1'b0, 1'b0);
      send_letter(5'd0, 1'b0, 1'b0);
      send_letter(5'd25, 1'b0, 1'b0);
      send_letter(5'd0, 1'b1, 1'b0);
      send_letter(5'd0, 1'b0, 1'b0);
      send_letter(5'd25, 1'b0, 1'b0);
      send_letter(5'd26, 1'b0, 1'b0);
      send_letter(5'd31, 1'b1, 1'b0);
      send_letter(5'd1, 1'b0, 1'b0);
      send_letter(5'd0, 1'b1, 1'b0);
      send_letter(5'd1, 1'b0, 1'b0);
      send_letter(5'd0, 1'b0, 1'b0);
      send_letter(5'd1, 1'b0, 1'b0);
      send_letter(5'd30, 1'b0, 1'b0);
      send_letter(5'd25, 1'b1, 1'b0);
      drain();

      // result side stalls long while items keep coming
      hold_rsp = 1'b1;
      for (int i = 0; i < 40; i++) send_letter(SYM_W'($urandom_range(0, 3)), 1'b0, 1'b0);
      drain();

      // random strings over small and full alphabets, with a few stray symbols
      for (int n = 0; n < 640; ) begin
         int wl;
         if ($urandom_range(0, 9) == 0) begin
            send_letter(SYM_W'($urandom_range(26, 31)), 1'($urandom_range(0, 1)), 1'b1);
            continue;
         end
         wl = $urandom_range(1, 20);
         send_word(wl, ($urandom_range(0, 2) == 0) ? 26 : $urandom_range(2, 4));
         n += wl;
      end
      drain();

      if (errors == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
